FILE: rtl/core/bb3_pkg.sv
// Shared types and constants of the 3x3 edge-aware box blur.
`default_nettype none

package bb3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam int CFG_W     = 11;
  localparam int RST_DIM   = 1024;
  localparam int CH_W      = 8;
  localparam int NCH       = 3;
  localparam int PIX_W     = NCH * CH_W;
  localparam int COL_W     = CH_W + 2;
  localparam int SUM_W     = CH_W + 4;
  localparam int OUT_DEPTH = 8;

  typedef logic [CH_W-1:0]  chan_t;
  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    CNT1,
    CNT2,
    CNT3,
    CNT4,
    CNT6,
    CNT9
  } cnt_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic top;
    logic bot;
    logic left;
    logic right;
    logic last;
  } tap_ctl_t;

  typedef struct packed {
    logic                       valid;
    logic                       last;
    cnt_t                       cnt;
    logic [NCH-1:0][SUM_W-1:0]  num;
  } mean_req_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
    logic  last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/bb3_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bb3_window.sv
// 3x3 window registers, masked column sums and rounded numerator stages.
`default_nettype none

module bb3_window (
  input  logic                clk,
  input  logic                rst_n,
  input  bb3_pkg::tap_ctl_t   tap,
  input  bb3_pkg::pix_t       up,
  input  bb3_pkg::pix_t       mid,
  input  bb3_pkg::pix_t       pix,
  output bb3_pkg::mean_req_t  req,
  output logic                busy
);

  import bb3_pkg::*;

  pix_t             win_r   [3][3];
  pix_t             win_nxt [3][3];
  pix_t             new_col [3];
  logic [COL_W-1:0] cs_r    [3][NCH];
  logic [COL_W-1:0] cs_nxt  [3][NCH];
  logic [2:0]       row_en;
  logic [1:0]       nrow;
  logic [1:0]       ncol;
  cnt_t             cnt_nxt;
  logic             p2_valid_r;
  logic             p2_left_r;
  logic             p2_right_r;
  logic             p2_last_r;
  cnt_t             p2_cnt_r;
  logic [SUM_W-1:0] half;
  mean_req_t        req_r;
  mean_req_t        req_nxt;

  always_comb begin
    new_col[0] = up;
    new_col[1] = mid;
    new_col[2] = pix;
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
      win_nxt[i][2] = new_col[i];
    end
    row_en = {~tap.bot, 1'b1, ~tap.top};
    for (int j = 0; j < 3; j++) begin
      for (int c = 0; c < NCH; c++) begin
        cs_nxt[j][c] = '0;
        for (int i = 0; i < 3; i++) begin
          if (row_en[i]) begin
            cs_nxt[j][c] = cs_nxt[j][c] + COL_W'(win_nxt[i][j][PIX_W-1-c*CH_W -: CH_W]);
          end
        end
      end
    end
    nrow = 2'd3 - 2'(tap.top) - 2'(tap.bot);
    ncol = 2'd3 - 2'(tap.left) - 2'(tap.right);
    case ({nrow, ncol})
      {2'd1, 2'd1}:               cnt_nxt = CNT1;
      {2'd1, 2'd2}, {2'd2, 2'd1}: cnt_nxt = CNT2;
      {2'd1, 2'd3}, {2'd3, 2'd1}: cnt_nxt = CNT3;
      {2'd2, 2'd2}:               cnt_nxt = CNT4;
      {2'd2, 2'd3}, {2'd3, 2'd2}: cnt_nxt = CNT6;
      {2'd3, 2'd3}:               cnt_nxt = CNT9;
      default:                    cnt_nxt = CNT1;
    endcase
  end

  always_comb begin
    case (p2_cnt_r)
      CNT2:    half = SUM_W'(1);
      CNT3:    half = SUM_W'(1);
      CNT4:    half = SUM_W'(2);
      CNT6:    half = SUM_W'(3);
      CNT9:    half = SUM_W'(4);
      default: half = '0;
    endcase
    req_nxt.valid = p2_valid_r;
    req_nxt.last  = p2_last_r;
    req_nxt.cnt   = p2_cnt_r;
    for (int c = 0; c < NCH; c++) begin
      req_nxt.num[c] = (p2_left_r ? SUM_W'(0) : SUM_W'(cs_r[0][c]))
                     + SUM_W'(cs_r[1][c])
                     + (p2_right_r ? SUM_W'(0) : SUM_W'(cs_r[2][c]))
                     + half;
    end
  end

  always_ff @(posedge clk) begin
    if (tap.valid) begin
      win_r <= win_nxt;
    end
    cs_r       <= cs_nxt;
    p2_left_r  <= tap.left;
    p2_right_r <= tap.right;
    p2_last_r  <= tap.last;
    p2_cnt_r   <= cnt_nxt;
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
      req_r      <= '0;
    end else begin
      p2_valid_r <= tap.valid & tap.emit;
      req_r      <= req_nxt;
    end
  end

  assign req  = req_r;
  assign busy = p2_valid_r;

endmodule

`default_nettype wire

FILE: rtl/core/bb3_div.sv
// Constant-divisor rounding divide of the neighborhood numerators.
`default_nettype none

module bb3_div (
  input  bb3_pkg::mean_req_t req,
  output bb3_pkg::res_t      res
);

  import bb3_pkg::*;

  localparam int RCP_W  = 16;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP3 = RCP_W'(43691);
  localparam logic [RCP_W-1:0] RECIP9 = RCP_W'(58255);
  localparam int SH3 = 17;
  localparam int SH9 = 19;

  logic [SUM_W-1:0]  op3  [NCH];
  logic [PROD_W-1:0] prod3 [NCH];
  logic [PROD_W-1:0] prod9 [NCH];
  chan_t             q    [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      op3[c]   = (req.cnt == CNT6) ? (req.num[c] >> 1) : req.num[c];
      prod3[c] = PROD_W'(op3[c]) * PROD_W'(RECIP3);
      prod9[c] = PROD_W'(req.num[c]) * PROD_W'(RECIP9);
      case (req.cnt)
        CNT1:       q[c] = CH_W'(req.num[c]);
        CNT2:       q[c] = CH_W'(req.num[c] >> 1);
        CNT4:       q[c] = CH_W'(req.num[c] >> 2);
        CNT3, CNT6: q[c] = CH_W'(prod3[c] >> SH3);
        CNT9:       q[c] = CH_W'(prod9[c] >> SH9);
        default:    q[c] = CH_W'(req.num[c]);
      endcase
    end
    res.red   = q[0];
    res.green = q[1];
    res.blue  = q[2];
    res.last  = req.last;
  end

endmodule

`default_nettype wire

FILE: rtl/core/bb3_fifo.sv
// Result queue between the blur pipeline and the output stream.
`default_nettype none

module bb3_fifo #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [WIDTH-1:0]             push_data,
  input  logic                         pop,
  output logic [WIDTH-1:0]             head,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_r, wr_nxt;
  logic [PW-1:0]    rd_r, rd_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head  = mem[rd_r];
  assign count = cnt_r;

endmodule

`default_nettype wire

FILE: rtl/core/box_blur_3x3_edge_aware.sv
// 3x3 edge-aware box blur on an RGB raster stream: top level.
//
// Takes one item per clock, sustained while in_tready is high, and gives one result per
// clock once the pipe is full and out_tready is high; each result is the rounded mean of
// the in-image 3x3 neighborhood of a pixel and leaves one row plus one pixel after that
// pixel enters, so drain items (tuser low) after the frame push out the last row. Both
// line buffers sit side by side in one RAM of MAX_WIDTH entries, read at the current
// column and written back in the cycle after; at an image width of one the written entry
// is forwarded to the next read. An accepted item's result passes the p1 registers, the
// window's p2 and request registers and the combinational divide into the output queue.
// The queue holds eight results and in_tready drops only when the queue plus the items
// in the pipe would fill it. Stale line buffer contents are masked, so no clearing pass
// runs after reset. A configuration write restarts the frame.
`default_nettype none

module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [bb3_pkg::PIX_W-1:0]    in_tdata,   // red_in, green_in, blue_in
  input  logic [0:0]                   in_tuser,   // is_pixel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [bb3_pkg::PIX_W-1:0]    out_tdata,  // red_out, green_out, blue_out
  output logic                         out_tlast,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [bb3_pkg::CFG_W-1:0]    cfg_wdata
);

  import bb3_pkg::*;

  localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int CWW = (CFG_W > WW) ? CFG_W : WW;
  localparam int CWH = (CFG_W > HW) ? CFG_W : HW;
  localparam int QCW = $clog2(OUT_DEPTH + 1);
  localparam int FW  = $clog2(OUT_DEPTH + 4);
  localparam int EW  = 2 * PIX_W;

  logic [CFG_W-1:0] w_r, h_r;
  logic [WW-1:0]    w_eff;
  logic [HW-1:0]    h_eff;
  logic [RW-1:0]    h_ext;

  logic [AW-1:0]    col_r, col_cur, col_nxt;
  logic [RW-1:0]    row_r, row_cur, row_nxt;
  logic [AW-1:0]    ec_r, ec_cur, ec_nxt;
  logic [RW-1:0]    er_r, er_cur, er_nxt;

  logic             acc, done, in_frame, live, col_wrap, emit;
  logic             top, bot, left, right;
  pix_t             pix;

  tap_ctl_t         p1_ctl_r, p1_ctl_nxt;
  logic [AW-1:0]    p1_addr_r;
  pix_t             p1_pix_r;
  logic             p1_fwd_r;
  logic [EW-1:0]    p1_fwd_data_r;

  logic [EW-1:0]    ram_rdata, entry, wb_data;
  mean_req_t        req;
  res_t             res, head;
  logic             busy;
  logic [QCW-1:0]   q_count;
  logic [FW-1:0]    fill;

  always_comb begin
    w_eff = (w_r == '0) ? WW'(1)
          : (CWW'(w_r) > CWW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(CWW'(w_r));
    h_eff = (h_r == '0) ? HW'(1)
          : (CWH'(h_r) > CWH'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(CWH'(h_r));
    h_ext = RW'(h_eff);
  end

  always_comb begin
    acc      = in_tvalid && in_tready;
    done     = er_r >= h_ext;
    col_cur  = done ? '0 : col_r;
    row_cur  = done ? '0 : row_r;
    ec_cur   = done ? '0 : ec_r;
    er_cur   = done ? '0 : er_r;
    in_frame = row_cur < h_ext;
    live     = acc && (in_tuser[0] || (!done && !in_frame));
    pix      = (in_tuser[0] && in_frame) ? {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]}
                                         : '0;
    col_wrap = (WW'(col_cur) + WW'(1)) >= w_eff;
    col_nxt  = col_wrap ? '0 : col_cur + AW'(1);
    row_nxt  = col_wrap ? row_cur + RW'(1) : row_cur;
    emit     = !((row_cur == '0) || ((row_cur == RW'(1)) && (col_cur == '0)));
    top      = er_cur == '0;
    bot      = (er_cur + RW'(1)) >= h_ext;
    left     = ec_cur == '0;
    right    = (WW'(ec_cur) + WW'(1)) >= w_eff;
    ec_nxt   = ec_cur;
    er_nxt   = er_cur;
    if (emit) begin
      ec_nxt = right ? '0 : ec_cur + AW'(1);
      er_nxt = right ? er_cur + RW'(1) : er_cur;
    end
    p1_ctl_nxt.valid = live;
    p1_ctl_nxt.emit  = emit;
    p1_ctl_nxt.top   = top;
    p1_ctl_nxt.bot   = bot;
    p1_ctl_nxt.left  = left;
    p1_ctl_nxt.right = right;
    p1_ctl_nxt.last  = bot && right;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r   <= CFG_W'(RST_DIM);
      h_r   <= CFG_W'(RST_DIM);
      col_r <= '0;
      row_r <= '0;
      ec_r  <= '0;
      er_r  <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_WIDTH) begin
        w_r <= cfg_wdata;
      end else begin
        h_r <= cfg_wdata;
      end
      col_r <= '0;
      row_r <= '0;
      ec_r  <= '0;
      er_r  <= '0;
    end else if (live) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      ec_r  <= ec_nxt;
      er_r  <= er_nxt;
    end
  end

  assign entry   = p1_fwd_r ? p1_fwd_data_r : ram_rdata;
  assign wb_data = {entry[PIX_W-1:0], p1_pix_r};

  always_ff @(posedge clk) begin
    p1_addr_r     <= col_cur;
    p1_pix_r      <= pix;
    p1_fwd_r      <= p1_ctl_r.valid && (p1_addr_r == col_cur);
    p1_fwd_data_r <= wb_data;
    if (!rst_n) begin
      p1_ctl_r <= '0;
    end else begin
      p1_ctl_r <= p1_ctl_nxt;
    end
  end

  bb3_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk   (clk),
    .we    (p1_ctl_r.valid),
    .waddr (p1_addr_r),
    .wdata (wb_data),
    .re    (live),
    .raddr (col_cur),
    .rdata (ram_rdata)
  );

  bb3_window u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .tap   (p1_ctl_r),
    .up    (entry[EW-1:PIX_W]),
    .mid   (entry[PIX_W-1:0]),
    .pix   (p1_pix_r),
    .req   (req),
    .busy  (busy)
  );

  bb3_div u_div (
    .req (req),
    .res (res)
  );

  bb3_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (req.valid),
    .push_data (res),
    .pop       (out_tvalid && out_tready),
    .head      (head),
    .count     (q_count)
  );

  assign fill = FW'(q_count) + FW'(p1_ctl_r.valid && p1_ctl_r.emit) + FW'(busy)
              + FW'(req.valid);
  assign in_tready  = fill < FW'(OUT_DEPTH);
  assign out_tvalid = q_count != '0;
  assign out_tdata  = {head.blue, head.green, head.red};
  assign out_tlast  = head.last;

endmodule

`default_nettype wire

FILE: rtl/core/bb3_checker.sv
// Port-level assertions of the box blur, bound to the top level.
`default_nettype none

module bb3_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [bb3_pkg::PIX_W-1:0]  out_tdata,
  input logic                       out_tlast
);

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_ready_backlog : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result waiting");

  a_reset_empty : assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 4))
    else $error("result without an item four cycles earlier");

endmodule

bind box_blur_3x3_edge_aware bb3_checker u_bb3_checker (.*);

`default_nettype wire
